@@ hw/rtl/stflp_pkg.sv @@
`default_nettype none

package stflp_pkg;

  localparam int unsigned OutW     = 32;
  localparam int unsigned SepW     = 8;
  localparam int unsigned ModW     = 31;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 31;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  localparam logic [CfgIdxW-1:0] CfgSeparator = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgModulus   = 1'b1;

  localparam logic [SepW-1:0] SepReset = 8'd44;
  localparam logic [ModW-1:0] ModReset = 31'd65536;

  localparam logic KindByte    = 1'b0;
  localparam logic KindRestart = 1'b1;

  localparam logic [7:0] CharNewline = 8'd10;
  localparam logic [7:0] CharTab     = 8'd9;
  localparam logic [7:0] CharCr      = 8'd13;
  localparam logic [7:0] CharSpace   = 8'd32;
  localparam logic [7:0] CharPlus    = 8'd43;
  localparam logic [7:0] CharMinus   = 8'd45;
  localparam logic [7:0] CharZero    = 8'd48;
  localparam logic [7:0] CharNine    = 8'd57;

  localparam logic [1:0] FieldFirst = 2'd0;
  localparam logic [1:0] FieldLast  = 2'd2;

  typedef enum logic [3:0] {
    PhSkip   = 4'b0001,
    PhSign   = 4'b0010,
    PhDigits = 4'b0100,
    PhDone   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic                   line_ok;
    logic signed [OutW-1:0] sequence_value;
    logic signed [OutW-1:0] speed_one;
    logic signed [OutW-1:0] speed_two;
    logic signed [OutW-1:0] lost_count;
    logic                   sample_lost;
  } out_item_t;

  typedef struct packed {
    logic            ok;
    logic            first;
    logic [OutW-1:0] seq;
    logic [OutW-1:0] spd1;
    logic [OutW-1:0] spd2;
  } line_t;

endpackage

`default_nettype wire

@@ hw/rtl/stflp_chan_if.sv @@
`default_nettype none

interface stflp_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/stflp_front.sv @@
`default_nettype none

module stflp_front #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [stflp_pkg::SepW-1:0]  sep_i,
  stflp_chan_if.sink                       in_i,
  stflp_chan_if.source                     line_o
);
  import stflp_pkg::*;

  localparam int unsigned ExtW = (VALUE_WIDTH > OutW) ? VALUE_WIDTH : OutW;

  function automatic logic [OutW-1:0] fval(input logic [VALUE_WIDTH-1:0] m, input logic n);
    logic [VALUE_WIDTH-1:0] v;
    logic [ExtW-1:0]        e;
    v = n ? (~m + 1'b1) : m;
    e = ExtW'(signed'(v));
    return e[OutW-1:0];
  endfunction

  logic                   first_q, first_d;
  logic [1:0]             idx_q, idx_d;
  phase_e                 phase_q, phase_d;
  logic                   char_after_q, char_after_d;
  logic [VALUE_WIDTH-1:0] mag_q [3];
  logic [VALUE_WIDTH-1:0] mag_d [3];
  logic                   neg_q [3];
  logic                   neg_d [3];

  in_item_t               item;
  logic                   accept;
  logic                   is_nl;
  logic                   is_digit;
  logic                   is_space;
  logic                   is_sign;
  logic [VALUE_WIDTH-1:0] cur;
  logic [VALUE_WIDTH+3:0] acc;
  logic [VALUE_WIDTH-1:0] sat;
  line_t                  line;

  assign item     = in_i.data;
  assign accept   = in_i.valid && in_i.ready;
  assign is_nl    = (item.kind == KindByte) && (item.byte_value == CharNewline);
  assign is_digit = (item.byte_value >= CharZero) && (item.byte_value <= CharNine);
  assign is_space = (item.byte_value == CharSpace) ||
                    ((item.byte_value >= CharTab) && (item.byte_value <= CharCr));
  assign is_sign  = (item.byte_value == CharPlus) || (item.byte_value == CharMinus);

  assign cur = mag_q[idx_q];
  assign acc = ({4'b0, cur} << 3) + ({4'b0, cur} << 1) +
               (VALUE_WIDTH+4)'(4'(item.byte_value - CharZero));
  assign sat = (|acc[VALUE_WIDTH+3:VALUE_WIDTH]) ? '1 : acc[VALUE_WIDTH-1:0];

  assign in_i.ready   = line_o.ready;
  assign line_o.valid = in_i.valid && is_nl;

  always_comb begin
    line.ok    = (idx_q == FieldLast) && char_after_q;
    line.first = first_q;
    line.seq   = fval(mag_q[0], neg_q[0]);
    line.spd1  = fval(mag_q[1], neg_q[1]);
    line.spd2  = fval(mag_q[2], neg_q[2]);
  end
  assign line_o.data = line;

  always_comb begin
    first_d      = first_q;
    idx_d        = idx_q;
    phase_d      = phase_q;
    char_after_d = char_after_q;
    mag_d        = mag_q;
    neg_d        = neg_q;
    if (accept) begin
      if (item.kind == KindRestart) begin
        first_d = 1'b1;
      end else if (is_nl) begin
        first_d      = 1'b0;
        idx_d        = FieldFirst;
        phase_d      = PhSkip;
        char_after_d = 1'b0;
        for (int i = 0; i < 3; i++) begin
          mag_d[i] = '0;
          neg_d[i] = 1'b0;
        end
      end else begin
        if (idx_q == FieldLast) begin
          char_after_d = 1'b1;
        end
        if ((idx_q != FieldLast) && (item.byte_value == sep_i)) begin
          idx_d        = idx_q + 2'd1;
          phase_d      = PhSkip;
          char_after_d = 1'b0;
        end else if ((phase_q == PhSkip) && is_space) begin
          phase_d = PhSkip;
        end else if ((phase_q == PhSkip) && is_sign) begin
          neg_d[idx_q] = (item.byte_value == CharMinus);
          phase_d      = PhSign;
        end else if ((phase_q != PhDone) && is_digit) begin
          mag_d[idx_q] = sat;
          phase_d      = PhDigits;
        end else begin
          phase_d = PhDone;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q      <= 1'b1;
      idx_q        <= FieldFirst;
      phase_q      <= PhSkip;
      char_after_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= '0;
        neg_q[i] <= 1'b0;
      end
    end else begin
      first_q      <= first_d;
      idx_q        <= idx_d;
      phase_q      <= phase_d;
      char_after_q <= char_after_d;
      mag_q        <= mag_d;
      neg_q        <= neg_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/stflp_queue.sv @@
`default_nettype none

module stflp_queue (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  stflp_chan_if.sink   push_i,
  stflp_chan_if.source pop_o
);
  import stflp_pkg::*;

  line_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QPtrW:0]   cnt_q, cnt_d;
  logic             push;
  logic             pop;

  assign push_i.ready = (cnt_q != (QPtrW+1)'(QDepth));
  assign pop_o.valid  = (cnt_q != '0);
  assign pop_o.data   = mem_q[rd_q];

  assign push = push_i.valid && push_i.ready;
  assign pop  = pop_o.valid && pop_o.ready;

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/stflp_back.sv @@
`default_nettype none

module stflp_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [stflp_pkg::ModW-1:0] mod_i,
  stflp_chan_if.sink                      line_i,
  stflp_chan_if.source                    out_o
);
  import stflp_pkg::*;

  logic [OutW-1:0] seq_q, seq_d;
  logic [OutW-1:0] spd1_q, spd1_d;
  logic [OutW-1:0] spd2_q, spd2_d;
  out_item_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;

  line_t           line;
  logic            pop;
  logic [OutW-1:0] exp_inc;
  logic [OutW-1:0] expected;
  logic [OutW-1:0] gap;

  assign line         = line_i.data;
  assign line_i.ready = !out_valid_q || out_o.ready;
  assign pop          = line_i.valid && line_i.ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.data   = out_q;

  always_comb begin
    exp_inc  = seq_q + 1'b1;
    expected = (!exp_inc[OutW-1] && (exp_inc >= {1'b0, mod_i})) ? '0 : exp_inc;
    seq_d    = line.ok ? line.seq  : seq_q;
    spd1_d   = line.ok ? line.spd1 : spd1_q;
    spd2_d   = line.ok ? line.spd2 : spd2_q;
    gap      = line.first ? '0 : (seq_d - expected);

    out_d.line_ok        = line.ok;
    out_d.sequence_value = seq_d;
    out_d.speed_one      = spd1_d;
    out_d.speed_two      = spd2_d;
    out_d.lost_count     = gap;
    out_d.sample_lost    = (gap != '0);

    if (pop) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= '0;
      spd1_q      <= '0;
      spd2_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        seq_q  <= seq_d;
        spd1_q <= spd1_d;
        spd2_q <= spd2_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sequenced_triple_field_line_parser_top.sv @@
// A newline word's line is queued, then loaded into the output register once
// that is free. Throughput: one word per cycle while the line queue has room;
// only a newline word makes a result, held in an output register behind a
// two-entry line queue. Reset (async, active low) clears parse state, stored
// values, queue and config to separator 44 and modulus 65536.
`default_nettype none

module sequenced_triple_field_line_parser_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [stflp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [stflp_pkg::CfgDataW-1:0] cfg_data_i,
  stflp_chan_if.sink                          in_i,
  stflp_chan_if.source                        out_o
);
  import stflp_pkg::*;

  logic [SepW-1:0] sep_q;
  logic [ModW-1:0] mod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SepReset;
      mod_q <= ModReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSeparator: sep_q <= cfg_data_i[SepW-1:0];
        CfgModulus:   mod_q <= cfg_data_i[ModW-1:0];
        default: ;
      endcase
    end
  end

  stflp_chan_if #(.T(line_t)) q_in  ();
  stflp_chan_if #(.T(line_t)) q_out ();

  stflp_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sep_i  (sep_q),
    .in_i   (in_i),
    .line_o (q_in)
  );

  stflp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_in),
    .pop_o  (q_out)
  );

  stflp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mod_i  (mod_q),
    .line_i (q_out),
    .out_o  (out_o)
  );

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_in.valid && !q_in.ready) |-> !(in_i.valid && in_i.ready))
    else $error("newline word accepted while line queue full");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_out.valid && q_out.ready) |=> out_o.valid)
    else $error("queued line did not reach output register");

  a_lost_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.sample_lost == (out_o.data.lost_count != '0)))
    else $error("sample_lost disagrees with lost_count");

  a_restart_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.data.kind == KindRestart) |-> !q_in.valid)
    else $error("restart word pushed a line");

endmodule

`default_nettype wire

@@ dv/tb_sequenced_triple_field_line_parser_top.sv @@
`timescale 1ns / 100ps

module tb_sequenced_triple_field_line_parser_top;
  import stflp_pkg::*;

  localparam int RandomWords = 2000;
  localparam int HoldCycles  = 300;
  localparam int StallLimit  = 3000;
  localparam int SettleCycles = 4;
  localparam int DrainCycles  = 8;

  typedef struct {
    bit        set_cfg;
    bit [7:0]  sep;
    bit [30:0] modulus;
    int        restart_at;
    bit        raw_prefix;
    string     text;
    bit        pinned;
    out_item_t result;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  stflp_chan_if #(.T(in_item_t))  in_if ();
  stflp_chan_if #(.T(out_item_t)) out_if ();

  sequenced_triple_field_line_parser_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // parser shadow state
  bit [SepW-1:0] sep_reg = SepReset;
  bit [ModW-1:0] mod_reg = ModReset;
  bit            first_line = 1'b1;
  bit [31:0]     seq_held;
  bit [31:0]     speed_held [2];
  bit [31:0]     mag [3];
  bit            neg [3];
  logic [1:0]    field_no = FieldFirst;
  phase_e        phase = PhSkip;
  bit            byte_after_sep;

  out_item_t pending_lines [$];
  out_item_t pinned_result [int];
  in_item_t  line_words [$];

  int  words_in, words_sent, lines_checked, cfg_writes, restarts_in, mismatches;
  int  quiet_cycles;
  bit  send_idle, recv_idle, hold_off_req;
  bit [7:0]  cur_sep = SepReset;
  bit [30:0] cur_mod = ModReset;
  bit [31:0] gen_seq;

  dir_row_t dir_rows [$] = '{
    '{0, 0, 0, -1, 0, "1,2,3\n", 1, '{1'b1, 1, 2, 3, 0, 1'b0}},
    '{0, 0, 0, -1, 0, "2,-5,+7\n", 1, '{1'b1, 2, -5, 7, 0, 1'b0}},
    '{0, 0, 0, -1, 0, "99999999999,-99999999999,2147483648\n", 1,
      '{1'b1, -1, 1, 32'h8000_0000, -4, 1'b1}},
    '{0, 0, 0, -1, 0, "5,6\n", 1, '{1'b0, -1, 1, 32'h8000_0000, -1, 1'b1}},
    '{0, 0, 0, -1, 0, "7,8,\n", 0, '0},
    '{0, 0, 0, -1, 0, " \011\013\014\015 9 , 10 ,11\n", 0, '0},
    '{0, 0, 0, -1, 0, "-,+,x\n", 0, '0},
    '{0, 0, 0, 0, 0, "0,0,0\n", 1, '{1'b1, 0, 0, 0, 0, 1'b0}},
    '{0, 0, 0, 3, 0, "3,4,5\n", 0, '0},
    '{0, 0, 0, -1, 1, ",1,2\n", 0, '0},
    '{0, 0, 0, -1, 0, "1,2,3,4\n", 0, '0},
    '{0, 0, 0, -1, 0, "+-5,--3,4\n", 0, '0},
    '{0, 0, 0, -1, 0, "\n", 0, '0},
    '{1, "5", 1, -1, 0, "151525\n", 0, '0},
    '{1, " ", 31'h7FFF_FFFF, -1, 0, "2147483646 1 2\n", 0, '0},
    '{0, 0, 0, -1, 0, "0 0 0\n", 1, '{1'b1, 0, 0, 0, 0, 1'b0}},
    '{1, "-", 7, -1, 0, "-3--4-5\n", 0, '0},
    '{1, 8'd10, 65536, -1, 0, "1,2,3\n", 0, '0},
    '{1, ",", 65536, -1, 0, "4,5,6\n", 0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int draw_gap(bit on);
    return on ? $urandom_range(0, 16) : 0;
  endfunction

  function automatic bit [31:0] field_word(int i);
    return neg[i] ? (32'd0 - mag[i]) : mag[i];
  endfunction

  function automatic void clear_line();
    for (int i = 0; i < 3; i++) begin
      mag[i] = '0;
      neg[i] = 1'b0;
    end
    field_no = FieldFirst;
    phase = PhSkip;
    byte_after_sep = 1'b0;
  endfunction

  function automatic void parse_number_byte(bit [7:0] b);
    bit        is_digit;
    bit        is_space;
    bit [31:0] d;
    is_digit = (b >= CharZero) && (b <= CharNine);
    is_space = (b == CharSpace) || ((b >= CharTab) && (b <= CharCr));
    d = 32'(b - CharZero);
    if (phase == PhSkip && is_space) begin
      return;
    end
    if (phase == PhSkip && (b == CharPlus || b == CharMinus)) begin
      neg[field_no] = (b == CharMinus);
      phase = PhSign;
      return;
    end
    if (phase != PhDone && is_digit) begin
      if (mag[field_no] > (32'hFFFF_FFFF - d) / 10) begin
        mag[field_no] = '1;
      end else begin
        mag[field_no] = mag[field_no] * 10 + d;
      end
      phase = PhDigits;
      return;
    end
    phase = PhDone;
  endfunction

  function automatic void advance_parser(input in_item_t w, output bit made,
                                         output out_item_t res);
    bit [31:0] next_seq;
    bit [31:0] gap;
    bit        ok;
    made = 1'b0;
    res = '0;
    if (w.kind == KindRestart) begin
      first_line = 1'b1;
      return;
    end
    if (w.byte_value != CharNewline) begin
      if (field_no >= FieldLast) begin
        byte_after_sep = 1'b1;
      end
      if (field_no < FieldLast && w.byte_value == sep_reg) begin
        field_no = field_no + 1'b1;
        phase = PhSkip;
        byte_after_sep = 1'b0;
      end else begin
        parse_number_byte(w.byte_value);
      end
      return;
    end
    next_seq = seq_held + 1;
    if (!next_seq[31] && next_seq >= {1'b0, mod_reg}) begin
      next_seq = '0;
    end
    ok = (field_no == FieldLast) && byte_after_sep;
    if (ok) begin
      seq_held = field_word(0);
      speed_held[0] = field_word(1);
      speed_held[1] = field_word(2);
    end
    if (first_line) begin
      first_line = 1'b0;
      gap = '0;
    end else begin
      gap = seq_held - next_seq;
    end
    clear_line();
    res.line_ok = ok;
    res.sequence_value = seq_held;
    res.speed_one = speed_held[0];
    res.speed_two = speed_held[1];
    res.lost_count = gap;
    res.sample_lost = (gap != 0);
    made = 1'b1;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    out_item_t calc;
    bit        made;
    bit        moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgSeparator) begin
          sep_reg = cfg_data_i[SepW-1:0];
        end else begin
          mod_reg = cfg_data_i[ModW-1:0];
        end
        cfg_writes++;
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        moved = 1'b1;
        if (pending_lines.size() == 0) begin
          mismatches++;
          $display("%0t: line result mismatch, expected none, actual seq %0d", $time,
                   got.sequence_value);
        end else begin
          want = pending_lines.pop_front();
          lines_checked++;
          check_field("line_ok", want.line_ok, got.line_ok);
          check_field("sequence_value", want.sequence_value, got.sequence_value);
          check_field("speed_one", want.speed_one, got.speed_one);
          check_field("speed_two", want.speed_two, got.speed_two);
          check_field("lost_count", want.lost_count, got.lost_count);
          check_field("sample_lost", want.sample_lost, got.sample_lost);
        end
      end
      if (in_if.valid && in_if.ready) begin
        moved = 1'b1;
        if (in_if.data.kind == KindRestart) begin
          restarts_in++;
        end
        advance_parser(in_if.data, made, calc);
        if (made) begin
          if (pinned_result.exists(words_in)) begin
            pending_lines.push_back(pinned_result[words_in]);
          end else begin
            pending_lines.push_back(calc);
          end
        end
        words_in++;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, StallLimit);
        $display("sequenced_triple_field_line_parser_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HoldCycles;
      end else begin
        gap = draw_gap(recv_idle);
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  task automatic send_word(logic kind, logic [7:0] b);
    int gap;
    gap = draw_gap(send_idle);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{kind: kind, byte_value: b};
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
  endtask

  // drain, settle, then write both registers
  task automatic set_config(bit [7:0] sep, bit [30:0] modulus);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_lines.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgSeparator;
    cfg_data_i <= CfgDataW'(sep);
    @(posedge clk_i);
    cfg_idx_i  <= CfgModulus;
    cfg_data_i <= CfgDataW'(modulus);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_sep = sep;
    cur_mod = modulus;
  endtask

  function automatic void push_word(logic kind, logic [7:0] b);
    line_words.push_back('{kind: kind, byte_value: b});
  endfunction

  function automatic void push_field(bit [31:0] v);
    string    digits;
    bit [7:0] junk;
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) begin
      push_word(KindByte, $urandom_range(0, 1) ? CharSpace : 8'(CharTab + $urandom_range(0, 4)));
    end
    case ($urandom_range(0, 5))
      0: push_word(KindByte, CharMinus);
      1: push_word(KindByte, CharPlus);
      default: ;
    endcase
    digits = ($urandom_range(0, 15) == 0) ? "99999999999" : $sformatf("%0d", v);
    for (int i = 0; i < digits.len(); i++) begin
      push_word(KindByte, digits[i]);
    end
    if ($urandom_range(0, 15) == 0) begin
      junk = 8'($urandom_range(0, 255));
      push_word(KindByte, (junk == CharNewline) ? CharSpace : junk);
    end
  endfunction

  function automatic bit [31:0] draw_speed();
    case ($urandom_range(0, 2))
      0: return $urandom_range(0, 999);
      1: return $urandom();
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // mostly well-formed records; some truncated, some noise, some after a restart
  function automatic void build_line();
    int        style;
    int        cut;
    bit [31:0] seq_pick;
    line_words.delete();
    style = $urandom_range(0, 9);
    if (style == 8) begin
      repeat ($urandom_range(0, 20)) push_word(KindByte, 8'($urandom_range(0, 255)));
    end else begin
      if (style == 9) begin
        push_word(KindRestart, 8'($urandom_range(0, 255)));
      end
      seq_pick = gen_seq;
      case ($urandom_range(0, 7))
        0: seq_pick = gen_seq + $urandom_range(1, 5);
        1: seq_pick = $urandom();
        default: ;
      endcase
      push_field(seq_pick);
      push_word(KindByte, cur_sep);
      push_field(draw_speed());
      push_word(KindByte, cur_sep);
      push_field(draw_speed());
      if (style == 7) begin
        cut = $urandom_range(0, line_words.size() - 1);
        while (line_words.size() > cut) void'(line_words.pop_back());
      end
      gen_seq = (longint'(seq_pick) + 1 >= cur_mod) ? '0 : seq_pick + 1;
    end
    push_word(KindByte, CharNewline);
  endfunction

  initial begin
    int        phase_no;
    int        phase_words;
    int        random_words;
    bit [7:0]  sep;
    bit [30:0] modulus;
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CfgSeparator;
    cfg_data_i <= '0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 1'b1;
    recv_idle = 1'b1;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].set_cfg) begin
        set_config(dir_rows[r].sep, dir_rows[r].modulus);
      end
      if (dir_rows[r].raw_prefix) begin
        send_word(KindByte, 8'h00);
        send_word(KindByte, 8'hFF);
      end
      for (int i = 0; i < dir_rows[r].text.len(); i++) begin
        if (i == dir_rows[r].restart_at) begin
          send_word(KindRestart, 8'($urandom_range(0, 255)));
        end
        if (dir_rows[r].pinned && dir_rows[r].text[i] == CharNewline) begin
          pinned_result[words_sent] = dir_rows[r].result;
        end
        send_word(KindByte, dir_rows[r].text[i]);
      end
    end

    phase_no = 0;
    random_words = 0;
    while (random_words < RandomWords) begin
      case (phase_no)
        0: begin sep = 8'h00; modulus = 31'd1; end
        1: begin sep = 8'hFF; modulus = 31'h7FFF_FFFF; end
        2: begin sep = ","; modulus = ModReset; end
        3: begin sep = "9"; modulus = 31'd5; end
        default: begin
          sep = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : ",";
          case ($urandom_range(0, 3))
            0: modulus = 31'd1;
            1: modulus = 31'h7FFF_FFFF;
            2: modulus = 31'($urandom_range(1, 100));
            default: modulus = 31'($urandom_range(1, 32'h7FFF_FFFF));
          endcase
        end
      endcase
      set_config(sep, modulus);
      send_idle = ($urandom_range(0, 2) != 0);
      recv_idle = ($urandom_range(0, 2) != 0);
      // hold the output while words keep coming
      if (phase_no == 2) begin
        send_idle = 1'b0;
        hold_off_req = 1'b1;
      end
      phase_words = 0;
      while (phase_words < 160) begin
        build_line();
        foreach (line_words[k]) begin
          send_word(line_words[k].kind, line_words[k].byte_value);
        end
        phase_words += line_words.size();
      end
      random_words += phase_words;
      phase_no++;
    end

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_lines.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Run: %0d words in (%0d restarts), %0d line results checked, %0d register writes",
             words_in, restarts_in, lines_checked, cfg_writes);
    $display("over %0d separator/modulus settings plus directed records", phase_no);
    if (mismatches == 0) begin
      $display("sequenced_triple_field_line_parser_top verification clean");
    end else begin
      $display("sequenced_triple_field_line_parser_top verification failed");
    end
    $finish;
  end

endmodule
